// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the OSD canvas checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OSDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("osdc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OSDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("osdc assertion failed");

`endif

// File: design/osdc_pkg.sv
// ----------------------------------------------------------------------------
// osdc_pkg
// Types and constants shared by the OSD canvas controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package osdc_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int CFG_W    = 9;   // size register width
	localparam int CFG_IDX_W = 2;  // register index width
	localparam int EDGE_W   = 16;
	localparam int COLOR_W  = 32;
	localparam int THICK_W  = 16;
	localparam int RDC_W    = 8;   // read column / row width
	localparam int PIX_W    = 16;
	localparam int CRD_W    = 13;  // clipped coordinate width
	localparam int SUM_W    = 17;  // coordinate plus thickness

	localparam logic [CFG_W-1:0] CFG_SIZE_RST = 9'd256;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_DRAW  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RSVD2  = 2'd2,
		REG_RSVD3  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		BAND_TOP    = 2'd0,
		BAND_BOTTOM = 2'd1,
		BAND_LEFT   = 2'd2,
		BAND_RIGHT  = 2'd3
	} band_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_CLR,
		ST_CLIP,
		ST_BAND,
		ST_SCAN,
		ST_RD,
		ST_FIN
	} st_t;

	typedef struct packed {
		logic  capture;
		logic  clr_step;
		logic  clip;
		logic  box_load;
		logic  pix_write;
		logic  result_load;
		band_t band;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic rect_empty;
		logic box_empty;
		logic scan_last;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: design/osdc_ctrl.sv
// ----------------------------------------------------------------------------
// osdc_ctrl
// Sequencer: clear sweep, clip, four band scans, pixel read, result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module osdc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         action,
	input  wire osdc_pkg::dp_sts_t  sts,
	output osdc_pkg::dp_cmd_t       cmd,
	output logic                    busy
);

	osdc_pkg::st_t   state_q, state_d;
	osdc_pkg::band_t band_q, band_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osdc_pkg::ST_INIT;
			band_q  <= osdc_pkg::BAND_TOP;
		end else begin
			state_q <= state_d;
			band_q  <= band_d;
		end
	end

	always_comb begin
		osdc_pkg::band_t band_nx;
		band_nx = osdc_pkg::BAND_TOP;
		unique case (band_q)
			osdc_pkg::BAND_TOP:    band_nx = osdc_pkg::BAND_BOTTOM;
			osdc_pkg::BAND_BOTTOM: band_nx = osdc_pkg::BAND_LEFT;
			osdc_pkg::BAND_LEFT:   band_nx = osdc_pkg::BAND_RIGHT;
			osdc_pkg::BAND_RIGHT:  band_nx = osdc_pkg::BAND_TOP;
			default:               band_nx = osdc_pkg::BAND_TOP;
		endcase

		state_d = state_q;
		band_d  = band_q;
		cmd     = '0;
		cmd.band = band_q;

		unique case (state_q)
			osdc_pkg::ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					unique case (osdc_pkg::act_t'(action))
						osdc_pkg::ACT_CLEAR: state_d = osdc_pkg::ST_CLR;
						osdc_pkg::ACT_DRAW:  state_d = osdc_pkg::ST_CLIP;
						osdc_pkg::ACT_READ:  state_d = osdc_pkg::ST_RD;
						default:             state_d = osdc_pkg::ST_FIN;
					endcase
				end
			end
			osdc_pkg::ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = osdc_pkg::ST_IDLE;
			end
			osdc_pkg::ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = osdc_pkg::ST_FIN;
			end
			osdc_pkg::ST_CLIP: begin
				cmd.clip = 1'b1;
				band_d   = osdc_pkg::BAND_TOP;
				state_d  = osdc_pkg::ST_BAND;
			end
			osdc_pkg::ST_BAND: begin
				if (sts.rect_empty) begin
					state_d = osdc_pkg::ST_FIN;
				end else begin
					cmd.box_load = 1'b1;
					state_d      = osdc_pkg::ST_SCAN;
				end
			end
			osdc_pkg::ST_SCAN: begin
				cmd.pix_write = !sts.box_empty;
				if (sts.box_empty || sts.scan_last) begin
					if (band_q == osdc_pkg::BAND_RIGHT) begin
						state_d = osdc_pkg::ST_FIN;
					end else begin
						band_d  = band_nx;
						state_d = osdc_pkg::ST_BAND;
					end
				end
			end
			osdc_pkg::ST_RD: begin
				state_d = osdc_pkg::ST_FIN;
			end
			osdc_pkg::ST_FIN: begin
				cmd.result_load = 1'b1;
				state_d         = osdc_pkg::ST_IDLE;
			end
			default: begin
				state_d = osdc_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != osdc_pkg::ST_IDLE);

endmodule

`default_nettype wire

// File: design/osdc_dp.sv
// ----------------------------------------------------------------------------
// osdc_dp
// Canvas store, size registers, clipping, band box scanner and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module osdc_dp #(
	parameter int MAX_WIDTH  = osdc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = osdc_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire osdc_pkg::dp_cmd_t                   cmd,
	output osdc_pkg::dp_sts_t                        sts,
	input  wire logic [1:0]                          action,
	input  wire logic signed [osdc_pkg::EDGE_W-1:0]  left_edge,
	input  wire logic signed [osdc_pkg::EDGE_W-1:0]  top_edge,
	input  wire logic signed [osdc_pkg::EDGE_W-1:0]  right_edge,
	input  wire logic signed [osdc_pkg::EDGE_W-1:0]  bottom_edge,
	input  wire logic [osdc_pkg::COLOR_W-1:0]        rect_color,
	input  wire logic [osdc_pkg::THICK_W-1:0]        line_thickness,
	input  wire logic [osdc_pkg::RDC_W-1:0]          read_column,
	input  wire logic [osdc_pkg::RDC_W-1:0]          read_row,
	input  wire logic                                cfg_wr,
	input  wire logic [osdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [osdc_pkg::CFG_W-1:0]          cfg_data,
	output logic [osdc_pkg::PIX_W-1:0]               pixel_value,
	output logic                                     pixel_valid,
	output logic                                     done
);

	localparam int CW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW    = CW + RW;
	localparam int DEPTH = 2 ** AW;
	localparam int CRD_W = osdc_pkg::CRD_W;
	localparam int SUM_W = osdc_pkg::SUM_W;

	function automatic logic [osdc_pkg::PIX_W-1:0] to_argb1555(
		input logic [osdc_pkg::COLOR_W-1:0] c
	);
		logic [osdc_pkg::PIX_W-1:0] px;
		px = {c[31], c[23:19], c[15:11], c[7:3]};
		return px;
	endfunction

	// size registers
	logic [osdc_pkg::CFG_W-1:0] cw_q, ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= osdc_pkg::CFG_SIZE_RST;
			ch_q <= osdc_pkg::CFG_SIZE_RST;
		end else if (cfg_wr) begin
			unique case (osdc_pkg::reg_idx_t'(cfg_index))
				osdc_pkg::REG_WIDTH:  cw_q <= cfg_data;
				osdc_pkg::REG_HEIGHT: ch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CRD_W-1:0] aw, ah;
	assign aw = (CRD_W'(cw_q) < CRD_W'(MAX_WIDTH))  ? CRD_W'(cw_q) : CRD_W'(MAX_WIDTH);
	assign ah = (CRD_W'(ch_q) < CRD_W'(MAX_HEIGHT)) ? CRD_W'(ch_q) : CRD_W'(MAX_HEIGHT);

	// captured command
	osdc_pkg::act_t                     act_q;
	logic signed [osdc_pkg::EDGE_W-1:0] left_q, top_q, right_q, bottom_q;
	logic [osdc_pkg::PIX_W-1:0]         px_q;
	logic [osdc_pkg::THICK_W-1:0]       thick_q;
	logic [osdc_pkg::RDC_W-1:0]         col_q, row_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= osdc_pkg::act_t'(action);
			left_q   <= left_edge;
			top_q    <= top_edge;
			right_q  <= right_edge;
			bottom_q <= bottom_edge;
			px_q     <= to_argb1555(rect_color);
			thick_q  <= (line_thickness == '0) ? osdc_pkg::THICK_W'(1) : line_thickness;
			col_q    <= read_column;
			row_q    <= read_row;
		end
	end

	// clip to the active canvas
	logic signed [SUM_W-1:0] l_s, t_s, r_s, b_s, aw_s, ah_s;
	logic signed [SUM_W-1:0] x1c, y1c, x2c, y2c;
	logic                    rect_empty_d;

	assign l_s  = {left_q[osdc_pkg::EDGE_W-1], left_q};
	assign t_s  = {top_q[osdc_pkg::EDGE_W-1], top_q};
	assign r_s  = {right_q[osdc_pkg::EDGE_W-1], right_q};
	assign b_s  = {bottom_q[osdc_pkg::EDGE_W-1], bottom_q};
	assign aw_s = signed'({{(SUM_W-CRD_W){1'b0}}, aw});
	assign ah_s = signed'({{(SUM_W-CRD_W){1'b0}}, ah});
	assign x1c  = (l_s < 0)    ? '0   : l_s;
	assign y1c  = (t_s < 0)    ? '0   : t_s;
	assign x2c  = (r_s > aw_s) ? aw_s : r_s;
	assign y2c  = (b_s > ah_s) ? ah_s : b_s;
	assign rect_empty_d = (aw == '0) || (ah == '0) || (r_s <= l_s) || (b_s <= t_s)
		|| (x2c <= x1c) || (y2c <= y1c);

	logic [CRD_W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic             rect_empty_q;

	always_ff @(posedge clk) begin
		if (cmd.clip) begin
			x1_q         <= x1c[CRD_W-1:0];
			y1_q         <= y1c[CRD_W-1:0];
			x2_q         <= x2c[CRD_W-1:0];
			y2_q         <= y2c[CRD_W-1:0];
			rect_empty_q <= rect_empty_d;
		end
	end

	// band bounds
	logic [SUM_W-1:0] y_end, x_end, y_beg, x_beg;
	logic [CRD_W-1:0] top_r1, bot_r0, left_c1, right_c0;

	assign y_end = SUM_W'(y1_q) + SUM_W'(thick_q);
	assign x_end = SUM_W'(x1_q) + SUM_W'(thick_q);
	assign y_beg = SUM_W'(y2_q) - SUM_W'(thick_q);
	assign x_beg = SUM_W'(x2_q) - SUM_W'(thick_q);

	assign top_r1   = (y_end < SUM_W'(ah)) ? y_end[CRD_W-1:0] : ah;
	assign left_c1  = (x_end < SUM_W'(aw)) ? x_end[CRD_W-1:0] : aw;
	assign bot_r0   = (SUM_W'(thick_q) >= SUM_W'(y2_q)) ? '0 : y_beg[CRD_W-1:0];
	assign right_c0 = (SUM_W'(thick_q) >= SUM_W'(x2_q)) ? '0 : x_beg[CRD_W-1:0];

	logic [CRD_W-1:0] r0_d, r1_d, c0_d, c1_d;

	always_comb begin
		r0_d = y1_q;
		r1_d = y2_q;
		c0_d = x1_q;
		c1_d = x2_q;
		unique case (cmd.band)
			osdc_pkg::BAND_TOP:    r1_d = top_r1;
			osdc_pkg::BAND_BOTTOM: r0_d = bot_r0;
			osdc_pkg::BAND_LEFT:   c1_d = left_c1;
			osdc_pkg::BAND_RIGHT:  c0_d = right_c0;
			default: ;
		endcase
	end

	// box scanner, row-major
	logic [CRD_W-1:0] r_q, c_q, c0_q, c1_q, r1_q;
	logic             box_empty_q;
	logic [CRD_W-1:0] c_inc, r_inc;
	logic             row_end;

	assign c_inc   = c_q + CRD_W'(1);
	assign r_inc   = r_q + CRD_W'(1);
	assign row_end = (c_inc == c1_q);

	always_ff @(posedge clk) begin
		if (cmd.box_load) begin
			r_q         <= r0_d;
			c_q         <= c0_d;
			c0_q        <= c0_d;
			c1_q        <= c1_d;
			r1_q        <= r1_d;
			box_empty_q <= (r0_d >= r1_d) || (c0_d >= c1_d);
		end else if (cmd.pix_write) begin
			if (row_end) begin
				c_q <= c0_q;
				r_q <= r_inc;
			end else begin
				c_q <= c_inc;
			end
		end
	end

	// clear sweep counter
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_step)
			clr_cnt_q <= clr_cnt_q + AW'(1);
	end

	// canvas store
	logic [osdc_pkg::PIX_W-1:0] mem [DEPTH];
	logic [osdc_pkg::PIX_W-1:0] rdata_q;
	logic                       we;
	logic [AW-1:0]              waddr, raddr;
	logic [osdc_pkg::PIX_W-1:0] wdata;
	logic [CRD_W-1:0]           rcol, rrow;

	assign rcol  = CRD_W'(col_q);
	assign rrow  = CRD_W'(row_q);
	assign raddr = {rrow[RW-1:0], rcol[CW-1:0]};
	assign we    = cmd.clr_step || cmd.pix_write;
	assign waddr = cmd.clr_step ? clr_cnt_q : {r_q[RW-1:0], c_q[CW-1:0]};
	assign wdata = cmd.clr_step ? '0 : px_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// result
	logic rd_hit;
	logic pixel_valid_q, done_q;
	logic [osdc_pkg::PIX_W-1:0] pixel_value_q;

	assign rd_hit = (act_q == osdc_pkg::ACT_READ) && (rcol < aw) && (rrow < ah);

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			pixel_value_q <= rd_hit ? rdata_q : '0;
			pixel_valid_q <= rd_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.result_load;
	end

	assign sts.clr_last   = &clr_cnt_q;
	assign sts.rect_empty = rect_empty_q;
	assign sts.box_empty  = box_empty_q;
	assign sts.scan_last  = row_end && (r_inc == r1_q);

	assign pixel_value = pixel_value_q;
	assign pixel_valid = pixel_valid_q;
	assign done        = done_q;

endmodule

`default_nettype wire

// File: design/rect_outline_osd_canvas.sv
// ----------------------------------------------------------------------------
// rect_outline_osd_canvas
// OSD canvas engine: ARGB1555 store with clear, rectangle outline draw and
// single pixel read.
// ----------------------------------------------------------------------------
//
// channel   | handshake              | payload
// ----------+------------------------+------------------------------------------
// command   | start / busy           | action, edges, rect_color, line_thickness,
//           |                        | read_column, read_row
// result    | done (1-cycle strobe)  | pixel_value, pixel_valid
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A command transfers when start is high and busy is low; one command runs
// at a time. Clear sweeps every store entry, one store entry written per
// cycle. Draw clips, then loads and scans each of the four bands in turn; an
// empty clipped rectangle ends the draw before any band is scanned.
// The single write port of the store sets the pace at one pixel per cycle
// while a band is scanned.
// After reset the block sweeps the store to zero with busy high; config
// writes are taken during the sweep.
// The receiver cannot stall: done lasts one cycle and is never held off.
//
`default_nettype none

module rect_outline_osd_canvas #(
	parameter int MAX_WIDTH  = osdc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = osdc_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	// command channel
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [1:0]                          action,
	input  wire logic signed [osdc_pkg::EDGE_W-1:0]  left_edge,
	input  wire logic signed [osdc_pkg::EDGE_W-1:0]  top_edge,
	input  wire logic signed [osdc_pkg::EDGE_W-1:0]  right_edge,
	input  wire logic signed [osdc_pkg::EDGE_W-1:0]  bottom_edge,
	input  wire logic [osdc_pkg::COLOR_W-1:0]        rect_color,
	input  wire logic [osdc_pkg::THICK_W-1:0]        line_thickness,
	input  wire logic [osdc_pkg::RDC_W-1:0]          read_column,
	input  wire logic [osdc_pkg::RDC_W-1:0]          read_row,

	// result channel
	output logic                                     done,
	output logic [osdc_pkg::PIX_W-1:0]               pixel_value,
	output logic                                     pixel_valid,

	// config write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [osdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [osdc_pkg::CFG_W-1:0]          cfg_data
);

	osdc_pkg::dp_cmd_t cmd;
	osdc_pkg::dp_sts_t sts;

	// size registers take a transfer every cycle
	assign cfg_ready = 1'b1;

	// sequencer: sweep, clip, band scans, read, result issue
	osdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// store, clipping, scanner and result registers
	osdc_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (action),
		.left_edge      (left_edge),
		.top_edge       (top_edge),
		.right_edge     (right_edge),
		.bottom_edge    (bottom_edge),
		.rect_color     (rect_color),
		.line_thickness (line_thickness),
		.read_column    (read_column),
		.read_row       (read_row),
		.cfg_wr         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixel_value    (pixel_value),
		.pixel_valid    (pixel_valid),
		.done           (done)
	);

endmodule

`default_nettype wire

// File: design/osdc_checker.sv
// ----------------------------------------------------------------------------
// osdc_checker
// Port-level checks on command/result sequencing of the OSD canvas.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module osdc_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         done,
	input wire logic [osdc_pkg::PIX_W-1:0]   pixel_value,
	input wire logic                         pixel_valid
);

	// accepted command always makes the block busy
	`OSDC_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// a result only follows a cycle of work
	`OSDC_ASSERT_NEXT(a_idle_no_done, clk, arst_n, !busy, !done)

	// a result marks the end of the command
	`OSDC_ASSERT_IMPL(a_done_ends, clk, arst_n, done, $fell(busy))

	// misses and non-read results carry a zero pixel
	`OSDC_ASSERT_IMPL(a_miss_zero, clk, arst_n, done && !pixel_valid, pixel_value == '0)

endmodule

bind rect_outline_osd_canvas osdc_checker u_osdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.pixel_value (pixel_value),
	.pixel_valid (pixel_valid)
);

`default_nettype wire
